// ===== hdl/priority_head_insert_ring_queue_top_assert.svh =====
// ---------------------------------------------------------------------------
// priority_head_insert_ring_queue_top assertion macros
// Implication checks used by the queue controller and datapath.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_HEAD_INSERT_RING_QUEUE_TOP_ASSERT_SVH
`define PRIORITY_HEAD_INSERT_RING_QUEUE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PHIRQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed");
// Next-cycle implication.
`define PHIRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed");
`else
`define PHIRQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define PHIRQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/phirq_pkg.sv =====
// ---------------------------------------------------------------------------
// phirq_pkg
// Shared types and codes of the priority head-insert ring queue.
// ---------------------------------------------------------------------------
package phirq_pkg;

   localparam int COUNT_W = 4;
   localparam int KIND_W  = 2;

   localparam logic [KIND_W-1:0] KIND_NORMAL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMERGENCY = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH_TAIL = 2'd0,
      OP_PUSH_HEAD = 2'd1,
      OP_POP       = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RSP_DONE  = 2'd0,
      RSP_FULL  = 2'd1,
      RSP_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       push;
      logic       front;
      logic       pop_rd;
      logic       pop_done;
      logic       report;
      status_type status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
   } stat_type;

endpackage

// ===== hdl/phirq_ram.sv =====
// ---------------------------------------------------------------------------
// phirq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module phirq_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/phirq_dpath.sv =====
// ---------------------------------------------------------------------------
// phirq_dpath
// Head and tail pointers, occupancy and kind tallies, entry store and
// result registers of the ring queue.
// ---------------------------------------------------------------------------
`include "priority_head_insert_ring_queue_top_assert.svh"

module phirq_dpath
   import phirq_pkg::*;
#(
   parameter int DEPTH    = 8,
   parameter int ID_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd_i,
   output stat_type            stat_o,
   input  logic [ID_WIDTH-1:0] req_vehicle_id,
   input  logic [KIND_W-1:0]   req_vehicle_kind,
   output logic [1:0]          rsp_status,
   output logic [ID_WIDTH-1:0] rsp_popped_id,
   output logic [KIND_W-1:0]   rsp_popped_kind,
   output logic [COUNT_W-1:0]  rsp_total_entries,
   output logic [COUNT_W-1:0]  rsp_emergency_entries,
   output logic [COUNT_W-1:0]  rsp_normal_entries
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = ID_WIDTH + KIND_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] head_dec, head_inc, tail_inc, wr_addr;
   logic [CW-1:0] occ_ff, occ_in, emg_ff, emg_in, nrm_ff, nrm_in;
   logic [EW-1:0] rd_data;
   logic [KIND_W-1:0]   kind_rd;
   logic [ID_WIDTH-1:0] id_rd;

   logic [1:0]          status_ff;
   logic [ID_WIDTH-1:0] pid_ff;
   logic [KIND_W-1:0]   pkind_ff;
   logic [COUNT_W-1:0]  total_ff, emg_out_ff, nrm_out_ff;

   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign wr_addr  = cmd_i.front ? head_dec : tail_inc;

   assign kind_rd = rd_data[EW-1:ID_WIDTH];
   assign id_rd   = rd_data[ID_WIDTH-1:0];

   assign stat_o.full  = (occ_ff == CW'(DEPTH));
   assign stat_o.empty = (occ_ff == '0);

   phirq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd_i.push),
      .wr_addr (wr_addr),
      .wr_data ({req_vehicle_kind, req_vehicle_id}),
      .rd_en   (cmd_i.pop_rd),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      emg_in  = emg_ff;
      nrm_in  = nrm_ff;
      if (cmd_i.push) begin
         occ_in = occ_ff + 1'b1;
         if (cmd_i.front) begin
            head_in = head_dec;
         end else begin
            tail_in = tail_inc;
         end
         if (req_vehicle_kind == KIND_EMERGENCY) begin
            emg_in = emg_ff + 1'b1;
         end else if (req_vehicle_kind == KIND_NORMAL) begin
            nrm_in = nrm_ff + 1'b1;
         end
      end else if (cmd_i.pop_done) begin
         occ_in  = occ_ff - 1'b1;
         head_in = head_inc;
         if (kind_rd == KIND_EMERGENCY && emg_ff != '0) begin
            emg_in = emg_ff - 1'b1;
         end else if (kind_rd == KIND_NORMAL && nrm_ff != '0) begin
            nrm_in = nrm_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= LAST_IDX;
         occ_ff  <= '0;
         emg_ff  <= '0;
         nrm_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         emg_ff  <= emg_in;
         nrm_ff  <= nrm_in;
      end
   end

   // Result registers hold until the next reported item.
   always_ff @(posedge clock) begin
      if (cmd_i.report) begin
         status_ff  <= cmd_i.status;
         pid_ff     <= cmd_i.pop_done ? id_rd : '0;
         pkind_ff   <= cmd_i.pop_done ? kind_rd : '0;
         total_ff   <= COUNT_W'(occ_in);
         emg_out_ff <= COUNT_W'(emg_in);
         nrm_out_ff <= COUNT_W'(nrm_in);
      end
   end

   assign rsp_status            = status_ff;
   assign rsp_popped_id         = pid_ff;
   assign rsp_popped_kind       = pkind_ff;
   assign rsp_total_entries     = total_ff;
   assign rsp_emergency_entries = emg_out_ff;
   assign rsp_normal_entries    = nrm_out_ff;

   `PHIRQ_ASSERT_NOW(a_occ_range, clock, reset, 1'b1, occ_ff <= CW'(DEPTH))
   `PHIRQ_ASSERT_NOW(a_tally_sum, clock, reset, 1'b1,
                     ({1'b0, emg_ff} + {1'b0, nrm_ff}) <= {1'b0, occ_ff})

endmodule

// ===== hdl/phirq_ctrl.sv =====
// ---------------------------------------------------------------------------
// phirq_ctrl
// Controller of the ring queue: decodes the operation, checks full and
// empty, sequences the pop through its read state and raises the result strobe.
// ---------------------------------------------------------------------------
`include "priority_head_insert_ring_queue_top_assert.svh"

module phirq_ctrl
   import phirq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_opcode,
   input  stat_type   stat_i,
   output cmd_type    cmd_o,
   output logic       busy,
   output logic       rsp_valid
);

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd_o    = '{push: 1'b0, front: 1'b0, pop_rd: 1'b0, pop_done: 1'b0,
                   report: 1'b0, status: RSP_DONE};
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(req_opcode))
                  OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                     cmd_o.report = 1'b1;
                     if (stat_i.full) begin
                        cmd_o.status = RSP_FULL;
                     end else begin
                        cmd_o.push  = 1'b1;
                        cmd_o.front = (op_type'(req_opcode) == OP_PUSH_HEAD);
                     end
                  end
                  OP_POP: begin
                     if (stat_i.empty) begin
                        cmd_o.report = 1'b1;
                        cmd_o.status = RSP_EMPTY;
                     end else begin
                        cmd_o.pop_rd = 1'b1;
                        state_in     = ST_POP;
                     end
                  end
                  default: begin
                     // Unused opcode reports done and changes nothing.
                     cmd_o.report = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd_o.pop_done = 1'b1;
            cmd_o.report   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd_o.report;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `PHIRQ_ASSERT_NEXT(a_pop_completes, clock, reset, cmd_o.pop_rd, cmd_o.pop_done)
   `PHIRQ_ASSERT_NOW(a_no_push_full, clock, reset, cmd_o.push, !stat_i.full)

endmodule

// ===== hdl/priority_head_insert_ring_queue_top.sv =====
// ---------------------------------------------------------------------------
// priority_head_insert_ring_queue_top
// Ring buffer deque: tail push, priority push in front of the head, head pop,
// with running occupancy and kind tallies reported on every item.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start & !busy        req_opcode, req_vehicle_id, req_vehicle_kind
//  response  rsp_valid, 1 cycle   rsp_status, rsp_popped_id, rsp_popped_kind,
//                                 rsp_total_entries, rsp_emergency_entries,
//                                 rsp_normal_entries
//
// For a push, a refused operation or an unused opcode the result
// appears the cycle after acceptance and busy stays low.
// A successful pop waits for the registered read of the entry
// RAM; busy is high for the cycle between acceptance and the read data.
// Synchronous reset empties the queue at once; the entry RAM is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module priority_head_insert_ring_queue_top
   import phirq_pkg::*;
#(
   parameter int DEPTH    = 8,
   parameter int ID_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [ID_WIDTH-1:0] req_vehicle_id,
   input  logic [KIND_W-1:0]   req_vehicle_kind,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [ID_WIDTH-1:0] rsp_popped_id,
   output logic [KIND_W-1:0]   rsp_popped_kind,
   output logic [COUNT_W-1:0]  rsp_total_entries,
   output logic [COUNT_W-1:0]  rsp_emergency_entries,
   output logic [COUNT_W-1:0]  rsp_normal_entries
);

   cmd_type  cmd;
   stat_type stat;

   phirq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat_i     (stat),
      .cmd_o      (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   phirq_dpath #(
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_i                 (cmd),
      .stat_o                (stat),
      .req_vehicle_id        (req_vehicle_id),
      .req_vehicle_kind      (req_vehicle_kind),
      .rsp_status            (rsp_status),
      .rsp_popped_id         (rsp_popped_id),
      .rsp_popped_kind       (rsp_popped_kind),
      .rsp_total_entries     (rsp_total_entries),
      .rsp_emergency_entries (rsp_emergency_entries),
      .rsp_normal_entries    (rsp_normal_entries)
   );

endmodule

// ===== tb/tb_priority_head_insert_ring_queue_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_priority_head_insert_ring_queue_top
// Drives tail pushes, priority head pushes, pops and unused opcodes into the
// ring queue, predicts each result from a local copy of the queue state and
// compares every returned item field by field, in order.
// ---------------------------------------------------------------------------
module tb_priority_head_insert_ring_queue_top
   import phirq_pkg::*;
();

   localparam int DEPTH      = 8;
   localparam int ID_WIDTH   = 16;
   localparam int STALL_MAX  = 1000;
   localparam int DRAIN_WAIT = 8;

   localparam logic [1:0]        OP_UNUSED  = 2'd3;
   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct {
      status_type          status;
      logic [ID_WIDTH-1:0] popped_id;
      logic [KIND_W-1:0]   popped_kind;
      logic [COUNT_W-1:0]  total;
      logic [COUNT_W-1:0]  emergency;
      logic [COUNT_W-1:0]  normal;
   } queue_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_opcode;
   logic [ID_WIDTH-1:0] req_vehicle_id;
   logic [KIND_W-1:0]   req_vehicle_kind;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [ID_WIDTH-1:0] rsp_popped_id;
   logic [KIND_W-1:0]   rsp_popped_kind;
   logic [COUNT_W-1:0]  rsp_total_entries;
   logic [COUNT_W-1:0]  rsp_emergency_entries;
   logic [COUNT_W-1:0]  rsp_normal_entries;

   // Local copy of the queue.
   logic [ID_WIDTH-1:0] slot_id   [DEPTH];
   logic [KIND_W-1:0]   slot_kind [DEPTH];
   logic [2:0]          head_ptr;
   logic [2:0]          tail_ptr;
   int                  held_count;
   int                  emergency_count;
   int                  normal_count;

   queue_result_type pending_results[$];
   int               error_count;
   int               stall_cycles;
   bit               idle_enable;

   priority_head_insert_ring_queue_top #(
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_vehicle_id        (req_vehicle_id),
      .req_vehicle_kind      (req_vehicle_kind),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_popped_id         (rsp_popped_id),
      .rsp_popped_kind       (rsp_popped_kind),
      .rsp_total_entries     (rsp_total_entries),
      .rsp_emergency_entries (rsp_emergency_entries),
      .rsp_normal_entries    (rsp_normal_entries)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void adjust_tally(input logic [KIND_W-1:0] kind, input bit up);
      if (kind == KIND_EMERGENCY) begin
         if (up) emergency_count++;
         else if (emergency_count > 0) emergency_count--;
      end else if (kind == KIND_NORMAL) begin
         if (up) normal_count++;
         else if (normal_count > 0) normal_count--;
      end
   endfunction

   // Applies one operation to the local queue and returns the result it causes.
   function automatic queue_result_type apply_queue_op(input logic [1:0] op,
                                                       input logic [ID_WIDTH-1:0] id,
                                                       input logic [KIND_W-1:0] kind);
      queue_result_type res;
      res.status      = RSP_DONE;
      res.popped_id   = '0;
      res.popped_kind = '0;
      if (op == OP_PUSH_TAIL || op == OP_PUSH_HEAD) begin
         if (held_count >= DEPTH) begin
            res.status = RSP_FULL;
         end else begin
            if (op == OP_PUSH_TAIL) begin
               tail_ptr = tail_ptr + 3'd1;
               slot_id[tail_ptr]   = id;
               slot_kind[tail_ptr] = kind;
            end else begin
               head_ptr = head_ptr - 3'd1;
               slot_id[head_ptr]   = id;
               slot_kind[head_ptr] = kind;
            end
            held_count++;
            adjust_tally(kind, 1'b1);
         end
      end else if (op == OP_POP) begin
         if (held_count == 0) begin
            res.status = RSP_EMPTY;
         end else begin
            res.popped_id   = slot_id[head_ptr];
            res.popped_kind = slot_kind[head_ptr];
            head_ptr = head_ptr + 3'd1;
            held_count--;
            adjust_tally(res.popped_kind, 1'b0);
         end
      end
      res.total     = held_count[COUNT_W-1:0];
      res.emergency = emergency_count[COUNT_W-1:0];
      res.normal    = normal_count[COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      error_count++;
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
   endtask

   // Sends one item, with an optional idle burst ahead of it, and records its
   // expected result once the block takes it.
   task automatic send_item(input logic [1:0] op, input logic [ID_WIDTH-1:0] id,
                            input logic [KIND_W-1:0] kind);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            <= 1'b1;
      req_opcode       <= op;
      req_vehicle_id   <= id;
      req_vehicle_kind <= kind;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(apply_queue_op(op, id, kind));
   endtask

   // Result checker: the receiver always takes the item on the strobe.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result item with no expectation pending", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_popped_id != want.popped_id)
               report_mismatch("popped_id", rsp_popped_id, want.popped_id);
            if (rsp_popped_kind != want.popped_kind)
               report_mismatch("popped_kind", rsp_popped_kind, want.popped_kind);
            if (rsp_total_entries != want.total)
               report_mismatch("total_entries", rsp_total_entries, want.total);
            if (rsp_emergency_entries != want.emergency)
               report_mismatch("emergency_entries", rsp_emergency_entries, want.emergency);
            if (rsp_normal_entries != want.normal)
               report_mismatch("normal_entries", rsp_normal_entries, want.normal);
         end
      end
   end

   // Watchdog on cycles in which neither an input nor a result item moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed_cases();
      send_item(OP_POP, 16'h5A5A, KIND_NORMAL);      // pop on empty
      send_item(OP_UNUSED, 16'hFFFF, KIND_SPARE);    // unused opcode on empty
      send_item(OP_PUSH_TAIL, 16'h0000, KIND_OTHER);
      send_item(OP_PUSH_TAIL, 16'hFFFF, KIND_EMERGENCY);
      send_item(OP_PUSH_HEAD, 16'h1234, KIND_NORMAL);
      send_item(OP_PUSH_HEAD, 16'hAAAA, KIND_SPARE); // kind 3 is held but not tallied
      send_item(OP_POP, 16'h0000, KIND_OTHER);
      for (int i = 0; i < 5; i++)
         send_item(i[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL, 16'h5555 << i[1:0],
                   i[0] ? KIND_EMERGENCY : KIND_NORMAL);
      // The queue is full here.
      send_item(OP_PUSH_TAIL, 16'h8001, KIND_EMERGENCY);
      send_item(OP_PUSH_HEAD, 16'h7FFE, KIND_NORMAL);
      send_item(OP_UNUSED, 16'h0F0F, KIND_OTHER);
      for (int i = 0; i < DEPTH; i++)
         send_item(OP_POP, ID_WIDTH'($urandom), KIND_W'($urandom_range(0, 3)));
      send_item(OP_POP, 16'hFFFF, KIND_SPARE);
   endtask

   // Runs filling or draining phases picked at random so that the queue
   // swings between full and empty and both pointers wrap many times.
   task automatic test_random_traffic(input int item_count);
      int          phase_left;
      bit          filling;
      int          pick;
      logic [1:0]  op;
      phase_left = 0;
      filling    = 1'b1;
      for (int i = 0; i < item_count; i++) begin
         if (phase_left == 0) begin
            filling    = ($urandom_range(0, 1) != 0);
            phase_left = $urandom_range(6, 40);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            op = OP_UNUSED;
         else if ((pick < 75) == filling)
            op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
         else
            op = OP_POP;
         send_item(op, ID_WIDTH'($urandom), KIND_W'($urandom_range(0, 3)));
      end
   endtask

   task automatic test_back_to_back(input int item_count);
      idle_enable = 1'b0;
      test_random_traffic(item_count);
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = OP_PUSH_TAIL;
      req_vehicle_id   = '0;
      req_vehicle_kind = KIND_OTHER;
      error_count      = 0;
      stall_cycles     = 0;
      idle_enable      = 1'b1;
      head_ptr         = 3'd0;
      tail_ptr         = 3'(DEPTH - 1);
      held_count       = 0;
      emergency_count  = 0;
      normal_count     = 0;
      for (int i = 0; i < DEPTH; i++) begin
         slot_id[i]   = '0;
         slot_kind[i] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(1500);
      test_back_to_back(200);

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== priority_head_insert_ring_queue_top.f =====
+incdir+hdl
hdl/phirq_pkg.sv
hdl/phirq_ram.sv
hdl/phirq_dpath.sv
hdl/phirq_ctrl.sv
hdl/priority_head_insert_ring_queue_top.sv
tb/tb_priority_head_insert_ring_queue_top.sv
